FILE: hw/rtl/css_pkg.sv
// Shared types and operation codes for the cursor sequence store.
package css_pkg;

    localparam logic [3:0] MODE_START       = 4'd0;
    localparam logic [3:0] MODE_END         = 4'd1;
    localparam logic [3:0] MODE_ADVANCE     = 4'd2;
    localparam logic [3:0] MODE_RETREAT     = 4'd3;
    localparam logic [3:0] MODE_INSERT      = 4'd4;
    localparam logic [3:0] MODE_ATTACH      = 4'd5;
    localparam logic [3:0] MODE_REMOVE      = 4'd6;
    localparam logic [3:0] MODE_INS_FRONT   = 4'd7;
    localparam logic [3:0] MODE_ATT_BACK    = 4'd8;
    localparam logic [3:0] MODE_REM_FRONT   = 4'd9;
    localparam logic [3:0] MODE_QUERY       = 4'd10;

    // Memory port control from the sequencer to the word store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_from_rd;
    } t_mem_ctl;

endpackage

FILE: hw/rtl/css_if.sv
// Valid/ready channel interfaces for operation and result transactions.
interface css_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  mode;
    logic [31:0] entry_value;
    logic [4:0]  read_index;

    modport source (output valid, output mode, output entry_value, output read_index,
                    input ready);
    modport sink   (input valid, input mode, input entry_value, input read_index,
                    output ready);
endinterface

interface css_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        has_current;
    logic [31:0] current_value;
    logic [5:0]  item_count;
    logic [31:0] read_value;
    logic        read_valid;

    modport source (output valid, output accepted, output has_current,
                    output current_value, output item_count, output read_value,
                    output read_valid, input ready);
    modport sink   (input valid, input accepted, input has_current,
                    input current_value, input item_count, input read_value,
                    input read_valid, output ready);
endinterface

FILE: hw/rtl/css_store.sv
// Word store: memory with one read port and one write port, and registered read data.
module css_store #(
    parameter int DEPTH     = 32,
    parameter int WORD_BITS = 32,
    parameter int AW        = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  css_pkg::t_mem_ctl    i_ctl,
    input  logic [AW-1:0]        i_waddr,
    input  logic [AW-1:0]        i_raddr,
    input  logic [WORD_BITS-1:0] i_word,
    output logic [WORD_BITS-1:0] o_rd_data
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    // A shift step writes back the word fetched in the cycle before
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_ctl.wr_from_rd ? r_rd_data : i_word;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/css_ctrl.sv
// Sequencer: decodes an operation, steps the shift loop, gathers the result.
module css_ctrl #(
    parameter int DEPTH     = 32,
    parameter int WORD_BITS = 32,
    parameter int AW        = $clog2(DEPTH),
    parameter int CW        = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    css_in_if.sink               i_in,
    css_out_if.source            o_out,
    output css_pkg::t_mem_ctl    o_ctl,
    output logic [AW-1:0]        o_waddr,
    output logic [AW-1:0]        o_raddr,
    output logic [WORD_BITS-1:0] o_word,
    input  logic [WORD_BITS-1:0] i_rd_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STEP = 3'd1;
    localparam logic [2:0] S_MOVE = 3'd2;
    localparam logic [2:0] S_PUT  = 3'd3;
    localparam logic [2:0] S_RCUR = 3'd4;
    localparam logic [2:0] S_RIDX = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_cursor, n_cursor;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_p, n_p;
    logic [CW-1:0]        r_lim, n_lim;
    logic                 r_open, n_open;
    logic                 r_ok, n_ok;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic [4:0]           r_ridx, n_ridx;
    logic [WORD_BITS-1:0] r_cur_val, n_cur_val;

    logic                 r_ov, n_ov;
    logic                 r_acc, n_acc;
    logic                 r_hc, n_hc;
    logic [31:0]          r_cv, n_cv;
    logic [5:0]           r_cnt, n_cnt;
    logic [31:0]          r_rv, n_rv;
    logic                 r_rvd, n_rvd;

    logic                 w_cur;
    logic                 w_room;
    logic [CW-1:0]        w_src;
    logic                 w_more;
    logic [63:0]          w_ent64;
    logic [63:0]          w_cv64;
    logic [63:0]          w_rd64;
    logic [31:0]          w_ridx32;
    logic [31:0]          w_cnt32;
    logic                 w_rvalid;

    assign w_cur    = r_cursor < r_count;
    assign w_room   = r_count < CW'(DEPTH);
    // Shared step unit: source index one below (open gap) or above (close gap)
    assign w_src    = r_open ? (r_i - CW'(1)) : (r_i + CW'(1));
    assign w_more   = r_open ? (r_i != r_p) : (w_src < r_lim);
    assign w_ent64  = 64'(i_in.entry_value);
    assign w_cv64   = 64'(r_cur_val);
    assign w_rd64   = 64'(i_rd_data);
    assign w_ridx32 = 32'(r_ridx);
    assign w_cnt32  = 32'(r_count);
    assign w_rvalid = w_ridx32 < w_cnt32;

    assign i_in.ready = (r_state == S_IDLE);
    assign o_word     = r_word;

    always_comb begin
        logic [CW-1:0] v_p;
        v_p       = '0;
        n_state   = r_state;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_i       = r_i;
        n_p       = r_p;
        n_lim     = r_lim;
        n_open    = r_open;
        n_ok      = r_ok;
        n_word    = r_word;
        n_ridx    = r_ridx;
        n_cur_val = r_cur_val;
        n_ov      = r_ov;
        n_acc     = r_acc;
        n_hc      = r_hc;
        n_cv      = r_cv;
        n_cnt     = r_cnt;
        n_rv      = r_rv;
        n_rvd     = r_rvd;
        o_ctl     = '0;
        o_waddr   = r_i[AW-1:0];
        o_raddr   = w_src[AW-1:0];

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_word  = w_ent64[WORD_BITS-1:0];
                    n_ridx  = i_in.read_index;
                    n_ok    = 1'b0;
                    n_lim   = r_count;
                    n_state = S_RCUR;
                    case (i_in.mode)
                        css_pkg::MODE_START: begin
                            n_cursor = '0;
                            n_ok     = 1'b1;
                        end
                        css_pkg::MODE_END: begin
                            if (r_count != '0) begin
                                n_cursor = r_count - CW'(1);
                                n_ok     = 1'b1;
                            end
                        end
                        css_pkg::MODE_ADVANCE: begin
                            if (w_cur) begin
                                n_cursor = r_cursor + CW'(1);
                                n_ok     = 1'b1;
                            end
                        end
                        css_pkg::MODE_RETREAT: begin
                            if (w_cur && r_cursor != '0) begin
                                n_cursor = r_cursor - CW'(1);
                                n_ok     = 1'b1;
                            end
                        end
                        css_pkg::MODE_INSERT, css_pkg::MODE_ATTACH,
                        css_pkg::MODE_INS_FRONT, css_pkg::MODE_ATT_BACK: begin
                            if (w_room) begin
                                case (i_in.mode)
                                    css_pkg::MODE_INSERT:
                                        v_p = w_cur ? r_cursor : '0;
                                    css_pkg::MODE_ATTACH:
                                        v_p = w_cur ? (r_cursor + CW'(1)) : r_count;
                                    css_pkg::MODE_INS_FRONT:
                                        v_p = '0;
                                    default:
                                        v_p = r_count;
                                endcase
                                n_p      = v_p;
                                n_i      = r_count;
                                n_open   = 1'b1;
                                n_cursor = v_p;
                                n_count  = r_count + CW'(1);
                                n_ok     = 1'b1;
                                n_state  = S_STEP;
                            end
                        end
                        css_pkg::MODE_REMOVE, css_pkg::MODE_REM_FRONT: begin
                            if (w_cur) begin
                                n_open  = 1'b0;
                                n_count = r_count - CW'(1);
                                n_ok    = 1'b1;
                                n_state = S_STEP;
                                if (i_in.mode == css_pkg::MODE_REMOVE) begin
                                    n_i = r_cursor;
                                end else begin
                                    n_i      = '0;
                                    n_cursor = '0;
                                end
                            end
                        end
                        css_pkg::MODE_QUERY: begin
                            n_ok = 1'b1;
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_STEP: begin
                if (w_more) begin
                    o_ctl.rd_en = 1'b1;
                    n_state     = S_MOVE;
                end else if (r_open) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_RCUR;
                end
            end
            S_MOVE: begin
                o_ctl.wr_en      = 1'b1;
                o_ctl.wr_from_rd = 1'b1;
                n_i              = w_src;
                n_state          = S_STEP;
            end
            S_PUT: begin
                o_ctl.wr_en = 1'b1;
                o_waddr     = r_p[AW-1:0];
                n_state     = S_RCUR;
            end
            S_RCUR: begin
                o_ctl.rd_en = 1'b1;
                o_raddr     = r_cursor[AW-1:0];
                n_state     = S_RIDX;
            end
            S_RIDX: begin
                n_cur_val   = w_cur ? i_rd_data : '0;
                o_ctl.rd_en = 1'b1;
                o_raddr     = w_ridx32[AW-1:0];
                n_state     = S_DONE;
            end
            S_DONE: begin
                // Hold until the previous result has left the output register
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_acc   = r_ok;
                    n_hc    = w_cur;
                    n_cv    = w_cv64[31:0];
                    n_cnt   = w_cnt32[5:0];
                    n_rvd   = w_rvalid;
                    n_rv    = w_rvalid ? w_rd64[31:0] : '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_p       <= n_p;
        r_lim     <= n_lim;
        r_open    <= n_open;
        r_ok      <= n_ok;
        r_word    <= n_word;
        r_ridx    <= n_ridx;
        r_cur_val <= n_cur_val;
        r_acc     <= n_acc;
        r_hc      <= n_hc;
        r_cv      <= n_cv;
        r_cnt     <= n_cnt;
        r_rv      <= n_rv;
        r_rvd     <= n_rvd;
    end

    assign o_out.valid         = r_ov;
    assign o_out.accepted      = r_acc;
    assign o_out.has_current   = r_hc;
    assign o_out.current_value = r_cv;
    assign o_out.item_count    = r_cnt;
    assign o_out.read_value    = r_rv;
    assign o_out.read_valid    = r_rvd;

endmodule

FILE: hw/rtl/cursor_sequence_store.sv
// Moves and queries pass through the cursor read, the index read and the result step before
// the result is registered. Shifting operations add a read and a write-back per word moved
// through the memory, a final loop check, and for an insert or attach a write of the new word.
// The next operation is taken while the last result waits to be read.
// Reset (synchronous, active low) empties the store; words at or above the count are
// never reported, so the memory needs no clearing pass.
module cursor_sequence_store #(
    parameter int DEPTH     = 32,
    parameter int WORD_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    css_in_if.sink    i_in,
    css_out_if.source o_out
);

    localparam int AW = $clog2(DEPTH);

    css_pkg::t_mem_ctl    w_ctl;
    logic [AW-1:0]        w_waddr;
    logic [AW-1:0]        w_raddr;
    logic [WORD_BITS-1:0] w_word;
    logic [WORD_BITS-1:0] w_rd_data;

    css_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_ctl     (w_ctl),
        .o_waddr   (w_waddr),
        .o_raddr   (w_raddr),
        .o_word    (w_word),
        .i_rd_data (w_rd_data)
    );

    css_store #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_waddr   (w_waddr),
        .i_raddr   (w_raddr),
        .i_word    (w_word),
        .o_rd_data (w_rd_data)
    );

endmodule

FILE: hw/rtl/css_check.sv
// Port-level checks for the cursor sequence store, bound to the top level.
module css_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_has_current,
    input logic [31:0] i_current_value,
    input logic        i_read_valid,
    input logic [31:0] i_read_value
);

    // A result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result transaction dropped before it was taken");

    // One operation at a time: no new transaction right after one is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready straight after an accepted transaction");

    a_cur_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_has_current |-> i_current_value == 32'd0)
        else $error("current value not zero without a current item");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_read_valid |-> i_read_value == 32'd0)
        else $error("read value not zero for an index beyond the count");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

endmodule

bind cursor_sequence_store css_check u_css_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_has_current   (o_out.has_current),
    .i_current_value (o_out.current_value),
    .i_read_valid    (o_out.read_valid),
    .i_read_value    (o_out.read_value)
);

FILE: bench/tb.sv
// Self-checking bench for cursor_sequence_store: random and directed operations, mirrored store.
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 2 * DEPTH + 16;

    typedef struct packed {
        logic [3:0]  mode;
        logic [31:0] entry_value;
        logic [4:0]  read_index;
    } t_seq_op;

    typedef struct packed {
        logic        accepted;
        logic        has_current;
        logic [31:0] current_value;
        logic [5:0]  item_count;
        logic [31:0] read_value;
        logic        read_valid;
    } t_store_report;

    logic i_clk;
    logic i_rst_n;

    css_in_if  op_if ();
    css_out_if rpt_if ();

    cursor_sequence_store dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_if),
        .o_out   (rpt_if)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Mirror of the store contents
    logic [31:0] mirror_words [DEPTH];
    int          mirror_count;
    int          mirror_cursor;

    t_seq_op       queued_ops [$];
    t_store_report predicted_reports [$];
    t_seq_op       offered_op;
    t_store_report oldest_report;

    int total_items;
    int items_sent;
    int reports_checked;
    int mismatches;
    int cycle_count;
    int send_gap_pct;
    int recv_gap_pct;
    int pause_at;
    int hold_at;
    int stall_left;
    bit stall_done;

    function automatic void shift_up(input int pos);
        for (int i = mirror_count; i > pos; i--)
            mirror_words[i] = mirror_words[i - 1];
    endfunction

    function automatic void shift_down(input int pos);
        for (int i = pos; i + 1 < mirror_count; i++)
            mirror_words[i] = mirror_words[i + 1];
        mirror_words[mirror_count - 1] = '0;
    endfunction

    function automatic t_store_report apply_seq_op(input t_seq_op op);
        t_store_report r;
        bit            here;
        bit            room;
        r    = '0;
        here = mirror_cursor < mirror_count;
        room = mirror_count < DEPTH;
        case (op.mode)
            css_pkg::MODE_START: begin
                mirror_cursor = 0;
                r.accepted = 1'b1;
            end
            css_pkg::MODE_END: if (mirror_count > 0) begin
                mirror_cursor = mirror_count - 1;
                r.accepted = 1'b1;
            end
            css_pkg::MODE_ADVANCE: if (here) begin
                mirror_cursor++;
                r.accepted = 1'b1;
            end
            css_pkg::MODE_RETREAT: if (here && mirror_cursor > 0) begin
                mirror_cursor--;
                r.accepted = 1'b1;
            end
            css_pkg::MODE_INSERT: if (room) begin
                if (!here)
                    mirror_cursor = 0;
                shift_up(mirror_cursor);
                mirror_words[mirror_cursor] = op.entry_value;
                mirror_count++;
                r.accepted = 1'b1;
            end
            css_pkg::MODE_ATTACH: if (room) begin
                if (!here) begin
                    mirror_words[mirror_count] = op.entry_value;
                    mirror_cursor = mirror_count;
                end else begin
                    shift_up(mirror_cursor + 1);
                    mirror_words[mirror_cursor + 1] = op.entry_value;
                    mirror_cursor++;
                end
                mirror_count++;
                r.accepted = 1'b1;
            end
            css_pkg::MODE_REMOVE: if (here) begin
                shift_down(mirror_cursor);
                mirror_count--;
                r.accepted = 1'b1;
            end
            css_pkg::MODE_INS_FRONT: if (room) begin
                shift_up(0);
                mirror_words[0] = op.entry_value;
                mirror_cursor = 0;
                mirror_count++;
                r.accepted = 1'b1;
            end
            css_pkg::MODE_ATT_BACK: if (room) begin
                mirror_words[mirror_count] = op.entry_value;
                mirror_cursor = mirror_count;
                mirror_count++;
                r.accepted = 1'b1;
            end
            css_pkg::MODE_REM_FRONT: if (here) begin
                shift_down(0);
                mirror_count--;
                mirror_cursor = 0;
                r.accepted = 1'b1;
            end
            css_pkg::MODE_QUERY: r.accepted = 1'b1;
            default: ;
        endcase
        here = mirror_cursor < mirror_count;
        r.has_current   = here;
        r.current_value = here ? mirror_words[mirror_cursor] : '0;
        r.item_count    = 6'(mirror_count);
        if (int'(op.read_index) < mirror_count) begin
            r.read_value = mirror_words[op.read_index];
            r.read_valid = 1'b1;
        end
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    int counted_ops;

    task automatic add_op(input logic [3:0] mode, input logic [31:0] value,
                          input logic [4:0] idx);
        t_seq_op op;
        op.mode        = mode;
        op.entry_value = value;
        op.read_index  = idx;
        queued_ops.push_back(op);
        if (mode <= css_pkg::MODE_QUERY)
            counted_ops++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [4:0] pick_index();
        return 5'($urandom_range(0, 31));
    endfunction

    // Driver: offers queued operations, mirrors each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            op_if.valid <= 1'b0;
        end else begin
            if (op_if.valid && op_if.ready) begin
                predicted_reports.push_back(apply_seq_op(offered_op));
                items_sent++;
            end
            if (!op_if.valid || op_if.ready) begin
                send_gap_pct = (items_sent < total_items / 3)     ? 36 :
                               (items_sent < 2 * total_items / 3) ? 79 : 0;
                // one pause mid-run until every outstanding report is back
                if (queued_ops.size() != 0
                        && !(items_sent == pause_at && predicted_reports.size() != 0)
                        && $urandom_range(0, 99) >= send_gap_pct) begin
                    offered_op = queued_ops.pop_front();
                    op_if.valid       <= 1'b1;
                    op_if.mode        <= offered_op.mode;
                    op_if.entry_value <= offered_op.entry_value;
                    op_if.read_index  <= offered_op.read_index;
                end else begin
                    op_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each report transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rpt_if.ready <= 1'b0;
        end else begin
            if (rpt_if.valid && rpt_if.ready) begin
                if (predicted_reports.size() == 0) begin
                    $error("report transaction with nothing predicted");
                    mismatches++;
                end else begin
                    oldest_report = predicted_reports.pop_front();
                    compare_field("accepted", 32'(oldest_report.accepted),
                                  32'(rpt_if.accepted));
                    compare_field("has_current", 32'(oldest_report.has_current),
                                  32'(rpt_if.has_current));
                    compare_field("current_value", oldest_report.current_value,
                                  rpt_if.current_value);
                    compare_field("item_count", 32'(oldest_report.item_count),
                                  32'(rpt_if.item_count));
                    compare_field("read_value", oldest_report.read_value,
                                  rpt_if.read_value);
                    compare_field("read_valid", 32'(oldest_report.read_valid),
                                  32'(rpt_if.read_valid));
                    reports_checked++;
                end
            end
            recv_gap_pct = (reports_checked < total_items / 3)     ? 79 :
                           (reports_checked < 2 * total_items / 3) ? 36 : 0;
            if (stall_left != 0) begin
                stall_left--;
                rpt_if.ready <= 1'b0;
            end else if (!stall_done && reports_checked >= hold_at) begin
                // long back-pressure so the block fills and stalls its input
                stall_left = 300;
                stall_done = 1'b1;
                rpt_if.ready <= 1'b0;
            end else begin
                rpt_if.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("cursor_sequence_store verification failed");
            $finish;
        end
    end

    initial begin
        int         kind;
        int         n;
        logic [3:0] m;

        i_rst_n            = 1'b0;
        op_if.valid        = 1'b0;
        op_if.mode         = css_pkg::MODE_QUERY;
        op_if.entry_value  = '0;
        op_if.read_index   = '0;
        rpt_if.ready       = 1'b0;
        foreach (mirror_words[i])
            mirror_words[i] = '0;
        mirror_count    = 0;
        mirror_cursor   = 0;
        items_sent      = 0;
        reports_checked = 0;
        mismatches      = 0;
        cycle_count     = 0;
        stall_left      = 0;
        stall_done      = 1'b0;
        counted_ops     = 0;

        // Directed: empty store, rejected moves, unknown modes, edge words
        add_op(css_pkg::MODE_QUERY,     32'h0000_0000, 5'd0);
        add_op(css_pkg::MODE_END,       32'h0000_0000, 5'd31);
        add_op(css_pkg::MODE_ADVANCE,   32'h0000_0000, 5'd0);
        add_op(css_pkg::MODE_RETREAT,   32'h0000_0000, 5'd0);
        add_op(css_pkg::MODE_REMOVE,    32'h0000_0000, 5'd0);
        add_op(css_pkg::MODE_REM_FRONT, 32'h0000_0000, 5'd0);
        add_op(4'hF,                    32'hFFFF_FFFF, 5'd31);
        add_op(css_pkg::MODE_INSERT,    32'hFFFF_FFFF, 5'd31);
        add_op(css_pkg::MODE_ATTACH,    32'h0000_0000, 5'd0);
        add_op(css_pkg::MODE_INS_FRONT, 32'h8000_0001, 5'd1);
        add_op(css_pkg::MODE_ATT_BACK,  32'h7FFF_FFFE, 5'd3);
        add_op(css_pkg::MODE_START,     32'h0000_0000, 5'd2);
        add_op(css_pkg::MODE_ADVANCE,   32'h0000_0000, 5'd1);
        add_op(css_pkg::MODE_RETREAT,   32'h0000_0000, 5'd0);
        add_op(css_pkg::MODE_END,       32'h0000_0000, 5'd3);
        add_op(css_pkg::MODE_ADVANCE,   32'h0000_0000, 5'd4);
        add_op(css_pkg::MODE_ATTACH,    32'hA5A5_5A5A, 5'd4);
        add_op(css_pkg::MODE_ADVANCE,   32'h0000_0000, 5'd4);
        add_op(css_pkg::MODE_INSERT,    32'h1234_5678, 5'd0);
        add_op(css_pkg::MODE_REMOVE,    32'h0000_0000, 5'd2);
        add_op(css_pkg::MODE_REM_FRONT, 32'h0000_0000, 5'd5);
        add_op(4'hB,                    32'h5555_5555, 5'd10);

        // Random: fill bursts run into the full store, drains, walks and noise
        while (counted_ops < 828) begin
            kind = $urandom_range(0, 19);
            if (kind < 3) begin
                n = $urandom_range(33, 38);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0:       m = css_pkg::MODE_INSERT;
                        1:       m = css_pkg::MODE_ATTACH;
                        2:       m = css_pkg::MODE_INS_FRONT;
                        default: m = css_pkg::MODE_ATT_BACK;
                    endcase
                    add_op(m, pick_word(), pick_index());
                end
            end else if (kind < 6) begin
                n = $urandom_range(10, 40);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0, 1, 2: m = css_pkg::MODE_REMOVE;
                        3, 4:    m = css_pkg::MODE_REM_FRONT;
                        default: m = css_pkg::MODE_START;
                    endcase
                    add_op(m, pick_word(), pick_index());
                end
            end else if (kind < 12) begin
                n = $urandom_range(5, 15);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0:       m = css_pkg::MODE_START;
                        1:       m = css_pkg::MODE_END;
                        2, 3:    m = css_pkg::MODE_ADVANCE;
                        4:       m = css_pkg::MODE_RETREAT;
                        default: m = css_pkg::MODE_QUERY;
                    endcase
                    add_op(m, pick_word(), pick_index());
                end
            end else begin
                n = $urandom_range(5, 10);
                repeat (n) begin
                    if ($urandom_range(0, 9) == 0)
                        m = 4'($urandom_range(11, 15));
                    else
                        m = 4'($urandom_range(0, 10));
                    add_op(m, pick_word(), pick_index());
                end
            end
        end

        total_items = queued_ops.size();
        pause_at    = total_items / 2;
        hold_at     = total_items * 5 / 6;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_sent != total_items || predicted_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("cursor_sequence_store verification clean");
        end else begin
            $display("cursor_sequence_store verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/css_pkg.sv
hw/rtl/css_if.sv
hw/rtl/css_store.sv
hw/rtl/css_ctrl.sv
hw/rtl/cursor_sequence_store.sv
hw/rtl/css_check.sv
bench/tb.sv
